// ===== design/cft_pkg.sv =====
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and codes of the CSV field tokenizer: character codes, token
// kinds, the token and burst records and the configuration write record.
// ----------------------------------------------------------------------------
package cft_pkg;

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_QUOTE = 8'd34;

	localparam logic [7:0] SEPARATOR_RESET  = 8'd44;
	localparam logic [7:0] SKIP_LINES_RESET = 8'd0;

	// register indexes
	localparam int         CFG_INDEX_W    = 1;
	localparam logic [0:0] REG_SEPARATOR  = 1'b0;
	localparam logic [0:0] REG_SKIP_LINES = 1'b1;

	// token kinds
	localparam logic [1:0] KIND_VALUE  = 2'd0;
	localparam logic [1:0] KIND_FIELD  = 2'd1;
	localparam logic [1:0] KIND_RECORD = 2'd2;

	// one input byte yields at most this many tokens
	localparam int SLOTS   = 3;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       dropped;
	} token_t;

	// tokens of one input byte, slot order is emission order
	typedef struct packed {
		logic   [SLOTS-1:0] valid;
		token_t [SLOTS-1:0] tok;
	} burst_t;

	typedef struct packed {
		logic                   en;
		logic [CFG_INDEX_W-1:0] index;
		logic [7:0]             data;
	} cfg_wr_t;

endpackage

// ===== design/cft_front.sv =====
// ----------------------------------------------------------------------------
// cft_front
// Accepts text bytes, tracks line skipping, CR folding and quote state, and
// turns each byte into a burst of up to three tokens for the queue.
// ----------------------------------------------------------------------------
module cft_front (
	input  logic            clk,
	input  logic            arst_n,
	input  cft_pkg::cfg_wr_t cfg,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      text_byte,
	input  logic            end_of_text,
	output logic            q_wr,
	output cft_pkg::burst_t q_data,
	input  logic            q_full
);
	import cft_pkg::*;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_QUOTED = 2'd1;
	localparam logic [1:0] MODE_QSEEN  = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic       emit;
		token_t     tok;
	} feed_t;

	function automatic feed_t feed(input logic [1:0] mode, input logic [7:0] c,
	                               input logic [7:0] sep);
		feed_t      r;
		logic [1:0] m;
		logic       done;
		r.mode        = mode;
		r.emit        = 1'b0;
		r.tok.kind    = KIND_VALUE;
		r.tok.value   = '0;
		r.tok.dropped = 1'b0;
		m             = mode;
		done          = 1'b0;
		if (m == MODE_QSEEN) begin
			if (c == CH_QUOTE) begin
				// doubled quote: one literal quote, stay quoted
				r.emit      = 1'b1;
				r.tok.value = CH_QUOTE;
				r.mode      = MODE_QUOTED;
				done        = 1'b1;
			end else begin
				m = MODE_NORMAL;
			end
		end
		if (!done) begin
			if (m == MODE_QUOTED) begin
				if (c == CH_QUOTE) begin
					r.mode = MODE_QSEEN;
				end else begin
					r.emit      = 1'b1;
					r.tok.value = c;
				end
			end else begin
				r.mode = MODE_NORMAL;
				if (c == CH_LF) begin
					r.emit     = 1'b1;
					r.tok.kind = KIND_RECORD;
				end else if (c == sep) begin
					r.emit     = 1'b1;
					r.tok.kind = KIND_FIELD;
				end else if (c == CH_QUOTE) begin
					r.mode = MODE_QUOTED;
				end else begin
					r.emit      = 1'b1;
					r.tok.value = c;
				end
			end
		end
		return r;
	endfunction

	logic [7:0] separator_q;
	logic [7:0] skip_lines_q;
	logic [1:0] mode_q;
	logic       cr_held_q;
	logic [7:0] lines_q;

	logic       accept;
	logic       skipping;
	logic       use_a;
	logic       use_b;
	logic       use_d;
	logic [1:0] mode_a;
	logic [1:0] mode_b;
	feed_t      fa;
	feed_t      fb;

	assign full     = q_full;
	assign accept   = push && !q_full;
	assign skipping = lines_q < skip_lines_q;

	always_comb begin
		// held CR goes out first unless this byte folds it into LF
		use_a  = cr_held_q && (text_byte != CH_LF);
		fa     = feed(mode_q, CH_CR, separator_q);
		mode_a = use_a ? fa.mode : mode_q;
		// a new CR is held, except at end of text where it passes as data
		use_b  = (text_byte != CH_CR) || end_of_text;
		fb     = feed(mode_a, text_byte, separator_q);
		mode_b = use_b ? fb.mode : mode_a;
		// supply the missing final LF, or close an open quote as dropped
		use_d  = end_of_text && ((mode_b == MODE_QUOTED) || (text_byte != CH_LF));

		q_data.tok[0]         = fa.tok;
		q_data.tok[1]         = fb.tok;
		q_data.tok[2].kind    = KIND_RECORD;
		q_data.tok[2].value   = '0;
		q_data.tok[2].dropped = (mode_b == MODE_QUOTED);
		q_data.valid[0]       = !skipping && use_a && fa.emit;
		q_data.valid[1]       = !skipping && use_b && fb.emit;
		q_data.valid[2]       = !skipping && use_d;
		q_wr                  = accept && (|q_data.valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q  <= SEPARATOR_RESET;
			skip_lines_q <= SKIP_LINES_RESET;
		end else if (cfg.en) begin
			case (cfg.index)
				REG_SEPARATOR:  separator_q  <= cfg.data;
				REG_SKIP_LINES: skip_lines_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			cr_held_q <= 1'b0;
			lines_q   <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				mode_q    <= MODE_NORMAL;
				cr_held_q <= 1'b0;
				lines_q   <= '0;
			end else if (skipping) begin
				if (text_byte == CH_LF) begin
					lines_q <= lines_q + 8'd1;
				end
			end else begin
				mode_q    <= mode_b;
				cr_held_q <= (text_byte == CH_CR);
			end
		end
	end

endmodule

// ===== design/cft_queue.sv =====
// ----------------------------------------------------------------------------
// cft_queue
// Short burst queue between the front and the back; each entry holds all
// tokens of one input byte.
// ----------------------------------------------------------------------------
module cft_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  cft_pkg::burst_t wr_data,
	output logic            q_full,
	input  logic            rd,
	output cft_pkg::burst_t head,
	output logic            nonempty
);
	import cft_pkg::*;

	burst_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign q_full   = (count_q == Q_CNT_W'(Q_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/cft_back.sv =====
// ----------------------------------------------------------------------------
// cft_back
// Walks the head burst one token a cycle into the output register while that
// register is free or popped, marks the final token of each burst and releases
// the entry after it.
module cft_back (
	input  logic            clk,
	input  logic            arst_n,
	input  cft_pkg::burst_t head,
	input  logic            nonempty,
	output logic            rd,
	input  logic            pop,
	output logic            empty,
	output logic [1:0]      token_kind,
	output logic [7:0]      value_byte,
	output logic            record_dropped,
	output logic            last_of_run
);
	import cft_pkg::*;

	logic [SLOTS-1:0] done_q;
	logic             out_valid_q;
	token_t           out_tok_q;
	logic             out_last_q;

	logic [SLOTS-1:0] avail;
	logic [SLOTS-1:0] pick;
	logic             last;
	logic             load;
	token_t           tok;

	always_comb begin
		avail = head.valid & ~done_q;
		pick  = avail & (~avail + 1'b1);
		last  = ((avail & ~pick) == '0);
		if (pick[0]) begin
			tok = head.tok[0];
		end else if (pick[1]) begin
			tok = head.tok[1];
		end else begin
			tok = head.tok[2];
		end
	end

	assign load = nonempty && (!out_valid_q || pop);
	assign rd   = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				done_q <= last ? '0 : (done_q | pick);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_tok_q  <= tok;
			out_last_q <= last;
		end
	end

	assign empty          = !out_valid_q;
	assign token_kind     = out_tok_q.kind;
	assign value_byte     = out_tok_q.value;
	assign record_dropped = out_tok_q.dropped;
	assign last_of_run    = out_last_q;

endmodule

// ===== design/csv_field_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit
// Streaming CSV tokenizer: one text byte in, value bytes, field ends and
// record ends out, with line skipping, CR LF folding and quoted fields.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     push / full            text_byte, end_of_text
//  result    empty / pop            token_kind, value_byte, record_dropped,
//                                   last_of_run
//  config    write_enable           reg_index, write_data
//
// A byte is taken every cycle while the burst queue has room; its tokens
// (zero to three) go via a queue entry into the output register and leave
// one per cycle while the output is popped, so the back side sets the rate
// when bursts of more than one token come in a row.
// Reset clears the parse state, the queue and the output valid flag.
// A stalled output holds the queue; full rises once all four entries wait.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [7:0]                      text_byte,
	input  logic                            end_of_text,
	output logic                            empty,
	input  logic                            pop,
	output logic [1:0]                      token_kind,
	output logic [7:0]                      value_byte,
	output logic                            record_dropped,
	output logic                            last_of_run,
	input  logic                            write_enable,
	input  logic [cft_pkg::CFG_INDEX_W-1:0] reg_index,
	input  logic [7:0]                      write_data
);
	import cft_pkg::*;

	cfg_wr_t cfg;
	burst_t  q_data;
	burst_t  head;
	logic    q_wr;
	logic    q_full;
	logic    q_rd;
	logic    q_nonempty;

	assign cfg.en    = write_enable;
	assign cfg.index = reg_index;
	assign cfg.data  = write_data;

	cft_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.push        (push),
		.full        (full),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.q_wr        (q_wr),
		.q_data      (q_data),
		.q_full      (q_full)
	);

	cft_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_data  (q_data),
		.q_full   (q_full),
		.rd       (q_rd),
		.head     (head),
		.nonempty (q_nonempty)
	);

	cft_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.nonempty       (q_nonempty),
		.rd             (q_rd),
		.pop            (pop),
		.empty          (empty),
		.token_kind     (token_kind),
		.value_byte     (value_byte),
		.record_dropped (record_dropped),
		.last_of_run    (last_of_run)
	);

	a_no_write_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !q_full)
		else $error("burst written into a full queue");

	a_no_read_when_empty : assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> q_nonempty)
		else $error("burst released from an empty queue");

	a_queued_burst_nonempty : assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> (q_data.valid != '0))
		else $error("burst without tokens queued");

	a_dropped_on_record : assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && record_dropped) |-> (token_kind == KIND_RECORD && last_of_run))
		else $error("dropped flag outside a final record end");

	a_value_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && token_kind != KIND_VALUE) |-> (value_byte == 8'd0))
		else $error("nonzero value byte on a field or record end");

endmodule
